// ----- src/edrp_pkg.sv -----
// shared types, constants and the type-code map for the engineering data record parser
`default_nettype none

package edrp_pkg;

    // result kinds
    localparam logic [2:0] KIND_NAME   = 3'd0;
    localparam logic [2:0] KIND_LABEL  = 3'd1;
    localparam logic [2:0] KIND_HEADER = 3'd2;
    localparam logic [2:0] KIND_DATA   = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // error causes
    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_MALFORMED = 2'd1;
    localparam logic [1:0] CAUSE_EARLY_END = 2'd2;

    // field lengths
    localparam int NAME_LEN      = 20;
    localparam int RCOUNT_DIGITS = 3;
    localparam int LLEN_DIGITS   = 2;
    localparam int DIM_DIGITS    = 4;
    localparam int SIZE_DIGITS   = 1;
    localparam int ECOUNT_DIGITS = 8;
    localparam int UNITS_LEN     = 2;

    // type letters
    localparam logic [7:0] LETTER_ASCII   = 8'h41;
    localparam logic [7:0] LETTER_BINARY  = 8'h42;
    localparam logic [7:0] LETTER_UINT    = 8'h49;
    localparam logic [7:0] LETTER_SINT    = 8'h53;
    localparam logic [7:0] LETTER_REAL    = 8'h52;
    localparam logic [7:0] LETTER_COMPLEX = 8'h43;

    // type codes
    localparam logic [3:0] TC_UNKNOWN = 4'd0;
    localparam logic [3:0] TC_ASCII   = 4'd1;
    localparam logic [3:0] TC_BINARY  = 4'd2;
    localparam logic [3:0] TC_UINT8   = 4'd3;
    localparam logic [3:0] TC_UINT16  = 4'd4;
    localparam logic [3:0] TC_UINT32  = 4'd5;
    localparam logic [3:0] TC_UINT64  = 4'd6;
    localparam logic [3:0] TC_INT8    = 4'd7;
    localparam logic [3:0] TC_INT16   = 4'd8;
    localparam logic [3:0] TC_INT32   = 4'd9;
    localparam logic [3:0] TC_INT64   = 4'd10;
    localparam logic [3:0] TC_FLOAT   = 4'd11;
    localparam logic [3:0] TC_DOUBLE  = 4'd12;
    localparam logic [3:0] TC_CPLX_F  = 4'd13;
    localparam logic [3:0] TC_CPLX_D  = 4'd14;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic        run_last;
        logic [9:0]  record_number;
        logic [6:0]  label_length;
        logic [13:0] column_count;
        logic [13:0] row_count;
        logic [3:0]  type_code;
        logic [3:0]  element_size;
        logic [15:0] units;
        logic [26:0] element_count;
        logic [1:0]  error_cause;
    } edrp_result_t;

    // results of one accepted byte, in order
    typedef struct packed {
        logic [1:0]   count;
        edrp_result_t first;
        edrp_result_t second;
    } edrp_push_t;

    // map type letter and element size to a type code
    function automatic logic [3:0] edrp_type_code(input logic [7:0] letter,
                                                  input logic [3:0] size);
        logic [3:0] code;
        code = TC_UNKNOWN;
        case (letter)
            LETTER_ASCII:  code = TC_ASCII;
            LETTER_BINARY: code = TC_BINARY;
            LETTER_UINT:
                case (size)
                    4'd1:    code = TC_UINT8;
                    4'd2:    code = TC_UINT16;
                    4'd4:    code = TC_UINT32;
                    4'd8:    code = TC_UINT64;
                    default: code = TC_UNKNOWN;
                endcase
            LETTER_SINT:
                case (size)
                    4'd1:    code = TC_INT8;
                    4'd2:    code = TC_INT16;
                    4'd4:    code = TC_INT32;
                    4'd8:    code = TC_INT64;
                    default: code = TC_UNKNOWN;
                endcase
            LETTER_REAL:
                case (size)
                    4'd4:    code = TC_FLOAT;
                    4'd8:    code = TC_DOUBLE;
                    default: code = TC_UNKNOWN;
                endcase
            LETTER_COMPLEX:
                case (size)
                    4'd4:    code = TC_CPLX_F;
                    4'd8:    code = TC_CPLX_D;
                    default: code = TC_UNKNOWN;
                endcase
            default: code = TC_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- src/edrp_parser.sv -----
// parse state and the per-byte decode step producing up to two results
`default_nettype none

module edrp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         byte_value,
    input  wire logic               first_byte,
    input  wire logic               final_byte,
    output edrp_pkg::edrp_push_t    push
);
    import edrp_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT, PH_NAME, PH_RCOUNT, PH_LLEN, PH_LABEL, PH_COLS,
        PH_ROWS, PH_TYPE, PH_SIZE, PH_UNITS, PH_ECOUNT, PH_DATA
    } phase_t;

    phase_t      phase_reg,        phase_next;
    logic [4:0]  field_pos_reg,    field_pos_next;
    logic [26:0] acc_reg,          acc_next;
    logic        digit_seen_reg,   digit_seen_next;
    logic        digits_ended_reg, digits_ended_next;
    logic [9:0]  records_total_reg, records_total_next;
    logic [9:0]  record_cnt_reg,   record_cnt_next;
    logic [29:0] bytes_left_reg,   bytes_left_next;
    logic [6:0]  label_len_reg,    label_len_next;
    logic [13:0] columns_reg,      columns_next;
    logic [13:0] rows_reg,         rows_next;
    logic [7:0]  letter_reg,       letter_next;
    logic [3:0]  size_reg,         size_next;
    logic [15:0] units_reg,        units_next;

    edrp_result_t main_res, extra_res;
    logic         main_vld, extra_vld;

    // one decode step
    always_comb
    begin
        logic        restart;
        logic        aborted;
        logic        is_digit;
        logic [4:0]  width;
        logic [26:0] count;
        logic [30:0] product;

        restart  = 1'b0;
        aborted  = 1'b0;
        is_digit = 1'b0;
        width    = 5'(DIM_DIGITS);
        count    = '0;
        product  = '0;
        main_res  = '0;
        extra_res = '0;
        main_vld  = 1'b0;
        extra_vld = 1'b0;

        phase_next         = phase_reg;
        field_pos_next     = field_pos_reg;
        acc_next           = acc_reg;
        digit_seen_next    = digit_seen_reg;
        digits_ended_next  = digits_ended_reg;
        records_total_next = records_total_reg;
        record_cnt_next    = record_cnt_reg;
        bytes_left_next    = bytes_left_reg;
        label_len_next     = label_len_reg;
        columns_next       = columns_reg;
        rows_next          = rows_reg;
        letter_next        = letter_reg;
        size_next          = size_reg;
        units_next         = units_reg;

        // first byte restarts everything
        if (first_byte)
        begin
            phase_next         = PH_NAME;
            field_pos_next     = '0;
            acc_next           = '0;
            digit_seen_next    = 1'b0;
            digits_ended_next  = 1'b0;
            records_total_next = '0;
            record_cnt_next    = '0;
            bytes_left_next    = '0;
            label_len_next     = '0;
            columns_next       = '0;
            rows_next          = '0;
            letter_next        = '0;
            size_next          = '0;
            units_next         = '0;
        end

        case (phase_next)
            PH_WAIT: ;
            PH_NAME:
            begin
                main_vld          = 1'b1;
                main_res.kind     = KIND_NAME;
                main_res.out_byte = byte_value;
                main_res.run_last = (field_pos_next == 5'(NAME_LEN - 1));
                field_pos_next    = field_pos_next + 5'd1;
                if (field_pos_next >= 5'(NAME_LEN))
                begin
                    restart    = 1'b1;
                    phase_next = PH_RCOUNT;
                end
            end
            PH_LABEL, PH_DATA:
            begin
                main_vld               = 1'b1;
                main_res.kind          = (phase_next == PH_LABEL) ? KIND_LABEL : KIND_DATA;
                main_res.out_byte      = byte_value;
                main_res.run_last      = (bytes_left_next == 30'd1);
                main_res.record_number = record_cnt_next;
                if (bytes_left_next != '0)
                    bytes_left_next = bytes_left_next - 30'd1;
                if (bytes_left_next == '0)
                begin
                    restart = 1'b1;
                    if (phase_next == PH_LABEL)
                        phase_next = PH_COLS;
                    else
                    begin
                        // record complete
                        record_cnt_next = record_cnt_next + 10'd1;
                        if (record_cnt_next == records_total_next)
                        begin
                            extra_vld      = 1'b1;
                            extra_res.kind = KIND_DONE;
                            phase_next     = PH_WAIT;
                        end
                        else
                            phase_next = PH_LLEN;
                    end
                end
            end
            PH_TYPE:
            begin
                letter_next = byte_value;
                restart     = 1'b1;
                phase_next  = PH_SIZE;
            end
            PH_UNITS:
            begin
                units_next     = {units_next[7:0], byte_value};
                field_pos_next = field_pos_next + 5'd1;
                if (field_pos_next >= 5'(UNITS_LEN))
                begin
                    restart    = 1'b1;
                    phase_next = PH_ECOUNT;
                end
            end
            default:
            begin
                // decimal fields
                case (phase_next)
                    PH_RCOUNT: width = 5'(RCOUNT_DIGITS);
                    PH_LLEN:   width = 5'(LLEN_DIGITS);
                    PH_SIZE:   width = 5'(SIZE_DIGITS);
                    PH_ECOUNT: width = 5'(ECOUNT_DIGITS);
                    default:   width = 5'(DIM_DIGITS);
                endcase
                is_digit = (byte_value >= 8'h30) && (byte_value <= 8'h39);
                if (!digits_ended_next)
                begin
                    if (is_digit)
                    begin
                        acc_next = (acc_next << 3) + (acc_next << 1)
                                   + {23'd0, byte_value[3:0]};
                        digit_seen_next = 1'b1;
                    end
                    else if (!(byte_value == 8'h20 && !digit_seen_next))
                        digits_ended_next = 1'b1;
                end
                field_pos_next = field_pos_next + 5'd1;
                if (field_pos_next >= width)
                begin
                    if (!digit_seen_next)
                    begin
                        // field with no digit
                        aborted                = 1'b1;
                        main_vld               = 1'b1;
                        main_res.kind          = KIND_ERROR;
                        main_res.record_number = record_cnt_next;
                        main_res.error_cause   = CAUSE_MALFORMED;
                        phase_next             = PH_WAIT;
                    end
                    else
                    begin
                        restart = 1'b1;
                        case (phase_next)
                            PH_RCOUNT:
                            begin
                                records_total_next = acc_next[9:0];
                                record_cnt_next    = '0;
                                if (acc_next[9:0] == '0)
                                begin
                                    main_vld      = 1'b1;
                                    main_res.kind = KIND_DONE;
                                    phase_next    = PH_WAIT;
                                end
                                else
                                    phase_next = PH_LLEN;
                            end
                            PH_LLEN:
                            begin
                                label_len_next  = acc_next[6:0];
                                bytes_left_next = {23'd0, acc_next[6:0]};
                                phase_next = (acc_next[6:0] != '0) ? PH_LABEL : PH_COLS;
                            end
                            PH_COLS:
                            begin
                                columns_next = acc_next[13:0];
                                phase_next   = PH_ROWS;
                            end
                            PH_ROWS:
                            begin
                                rows_next  = acc_next[13:0];
                                phase_next = PH_TYPE;
                            end
                            PH_SIZE:
                            begin
                                size_next  = acc_next[3:0];
                                units_next = '0;
                                phase_next = PH_UNITS;
                            end
                            default:
                            begin
                                // element count completes the header
                                count   = acc_next;
                                product = 31'(size_next) * 31'(count);
                                main_vld               = 1'b1;
                                main_res.kind          = KIND_HEADER;
                                main_res.record_number = record_cnt_next;
                                main_res.label_length  = label_len_next;
                                main_res.column_count  = columns_next;
                                main_res.row_count     = rows_next;
                                main_res.type_code     = edrp_type_code(letter_next, size_next);
                                main_res.element_size  = size_next;
                                main_res.units         = units_next;
                                main_res.element_count = count;
                                bytes_left_next        = product[29:0];
                                if (product[29:0] == '0)
                                begin
                                    record_cnt_next = record_cnt_next + 10'd1;
                                    if (record_cnt_next == records_total_next)
                                    begin
                                        extra_vld      = 1'b1;
                                        extra_res.kind = KIND_DONE;
                                        phase_next     = PH_WAIT;
                                    end
                                    else
                                        phase_next = PH_LLEN;
                                end
                                else
                                    phase_next = PH_DATA;
                            end
                        endcase
                    end
                end
            end
        endcase

        // new field starts clean
        if (restart)
        begin
            field_pos_next    = '0;
            acc_next          = '0;
            digit_seen_next   = 1'b0;
            digits_ended_next = 1'b0;
        end

        // buffer ended before the block did
        if (!aborted && final_byte && phase_next != PH_WAIT)
        begin
            extra_vld               = 1'b1;
            extra_res               = '0;
            extra_res.kind          = KIND_ERROR;
            extra_res.record_number = record_cnt_next;
            extra_res.error_cause   = CAUSE_EARLY_END;
            phase_next              = PH_WAIT;
        end
    end

    // pack results in order, only for an accepted byte
    always_comb
    begin
        push.count  = '0;
        push.first  = main_vld ? main_res : extra_res;
        push.second = extra_res;
        if (accept)
            push.count = {1'b0, main_vld} + {1'b0, extra_vld};
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT;
            field_pos_reg     <= '0;
            acc_reg           <= '0;
            digit_seen_reg    <= 1'b0;
            digits_ended_reg  <= 1'b0;
            records_total_reg <= '0;
            record_cnt_reg    <= '0;
            bytes_left_reg    <= '0;
            label_len_reg     <= '0;
            columns_reg       <= '0;
            rows_reg          <= '0;
            letter_reg        <= '0;
            size_reg          <= '0;
            units_reg         <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            field_pos_reg     <= field_pos_next;
            acc_reg           <= acc_next;
            digit_seen_reg    <= digit_seen_next;
            digits_ended_reg  <= digits_ended_next;
            records_total_reg <= records_total_next;
            record_cnt_reg    <= record_cnt_next;
            bytes_left_reg    <= bytes_left_next;
            label_len_reg     <= label_len_next;
            columns_reg       <= columns_next;
            rows_reg          <= rows_next;
            letter_reg        <= letter_next;
            size_reg          <= size_next;
            units_reg         <= units_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/edrp_result_fifo.sv -----
// four-entry result queue taking up to two results per cycle
`default_nettype none

module edrp_result_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire edrp_pkg::edrp_push_t push,
    input  wire logic                 pop,
    output edrp_pkg::edrp_result_t    head,
    output logic                      not_empty,
    output logic                      room_for_two
);
    import edrp_pkg::*;

    edrp_result_t mem_reg [4];
    logic [1:0]   wr_ptr_reg, wr_ptr_next;
    logic [1:0]   rd_ptr_reg, rd_ptr_next;
    logic [2:0]   count_reg,  count_next;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= 3'd2);

    // storage
    always_ff @(posedge clk)
    begin
        if (push.count != '0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + 2'd1] <= push.second;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/engineering_data_record_parser_core.sv -----
// top level of the engineering data record parser
`default_nettype none

//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+--------------------------------------------
//  bytes in | byte_valid    | byte_stall    | byte_value, first_byte, final_byte
//  results  | result_valid  | result_stall  | kind, out_byte, run_last, record_number, ...
//
//  one byte per cycle is decoded on transfer; its results enter a four-entry queue
//  and appear on the result port from the next cycle, one result per transfer.
//  a byte can produce two results, so a steady run of such bytes
//  is limited by the single result port.
//  byte_stall rises when the queue has room for fewer than two results.
//  reset returns the parser to waiting for a first byte and empties the queue.

module engineering_data_record_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  byte_value,
    input  wire logic        first_byte,
    input  wire logic        final_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       kind,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic [9:0]       record_number,
    output logic [6:0]       label_length,
    output logic [13:0]      column_count,
    output logic [13:0]      row_count,
    output logic [3:0]       type_code,
    output logic [3:0]       element_size,
    output logic [15:0]      units,
    output logic [26:0]      element_count,
    output logic [1:0]       error_cause
);
    import edrp_pkg::*;

    edrp_push_t   push;
    edrp_result_t head;
    logic         accept;
    logic         pop;
    logic         not_empty;
    logic         room_for_two;

    // handshakes
    assign byte_stall   = !room_for_two;
    assign accept       = byte_valid && room_for_two;
    assign result_valid = not_empty;
    assign pop          = not_empty && !result_stall;

    // decode
    edrp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_value (byte_value),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .push       (push)
    );

    // result queue
    edrp_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pop          (pop),
        .head         (head),
        .not_empty    (not_empty),
        .room_for_two (room_for_two)
    );

    // result fields
    assign kind          = head.kind;
    assign out_byte      = head.out_byte;
    assign run_last      = head.run_last;
    assign record_number = head.record_number;
    assign label_length  = head.label_length;
    assign column_count  = head.column_count;
    assign row_count     = head.row_count;
    assign type_code     = head.type_code;
    assign element_size  = head.element_size;
    assign units         = head.units;
    assign element_count = head.element_count;
    assign error_cause   = head.error_cause;

endmodule

`default_nettype wire
